[rtl/vkt_pkg.sv]
// Package for the versioned key table: field widths, status codes, opcodes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package vkt_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int KEY_BITS_DEF = 64;

    localparam int KEY_W       = 64;
    localparam int VER_W       = 31;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 6;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 16;
    localparam int VER_LSB     = KEY_W;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_NEWER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } vkt_cmd_t;

    typedef struct packed {
        logic is_add;
        logic full;
        logic hit;
        logic done;
        logic out_free;
    } vkt_sts_t;

endpackage

[rtl/vkt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module vkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/vkt_ctrl.sv]
// Controller state machine for the versioned key table.
// Depends on vkt_pkg for the command and status structs.
module vkt_ctrl import vkt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  vkt_sts_t sts,
    output vkt_cmd_t cmd
);

    localparam int          STATE_W = 1;
    localparam logic [STATE_W-1:0] S_IDLE = 1'b0;
    localparam logic [STATE_W-1:0] S_SCAN = 1'b1;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic               decide;

    assign decide = (sts.is_add && sts.full) || sts.hit || sts.done;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        cmd.finish  = 1'b0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (decide)
                begin
                    if (sts.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/vkt_datapath.sv]
// Datapath of the versioned key table: item registers, key and version RAMs,
// scan counter, entry count and the result register.
// Depends on vkt_pkg and vkt_ram.
module vkt_datapath import vkt_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   in_op,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data,
    input  vkt_cmd_t               cmd,
    output vkt_sts_t               sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VER_W-1:0]    ver_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       sidx_reg;
    logic [AW-1:0]       cidx_reg;
    logic                cvld_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                issue_ok;
    logic                re;
    logic [KEY_BITS-1:0] key_rdata;
    logic [VER_W-1:0]    ver_rdata;
    logic                full;
    logic                hit;
    logic                key_we;
    logic                ver_we;
    logic [AW-1:0]       ver_waddr;
    logic [STATUS_W-1:0] status_next;
    logic [CW-1:0]       cnt_next;

    assign issue_ok = sidx_reg < cnt_reg;
    assign re       = cmd.step && issue_ok;
    assign full     = (cnt_reg == DEPTH_C);
    assign hit      = cvld_reg && (key_rdata == key_reg);

    assign sts.is_add   = (op_reg == OP_ADD);
    assign sts.full     = full;
    assign sts.hit      = hit;
    assign sts.done     = !cvld_reg && !issue_ok;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        key_we      = 1'b0;
        ver_we      = 1'b0;
        ver_waddr   = cnt_reg[AW-1:0];
        cnt_next    = cnt_reg;
        status_next = ST_NOT_FOUND;
        if (op_reg == OP_ADD)
        begin
            priority if (full)
            begin
                status_next = ST_FULL;
            end
            else if (hit)
            begin
                status_next = ST_DUP;
            end
            else
            begin
                status_next = ST_ADDED;
                key_we      = cmd.finish;
                ver_we      = cmd.finish;
                cnt_next    = cnt_reg + 1'b1;
            end
        end
        else
        begin
            ver_waddr = cidx_reg;
            priority if (!hit)
            begin
                status_next = ST_NOT_FOUND;
            end
            else if (ver_rdata < ver_reg)
            begin
                status_next = ST_UPDATED;
                ver_we      = cmd.finish;
            end
            else
            begin
                status_next = ST_NOT_NEWER;
            end
        end
    end

    vkt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (key_reg),
        .re    (re),
        .raddr (sidx_reg[AW-1:0]),
        .rdata (key_rdata)
    );

    vkt_ram #(
        .WIDTH (VER_W),
        .DEPTH (DEPTH)
    ) u_ver_ram (
        .clk   (clk),
        .we    (ver_we),
        .waddr (ver_waddr),
        .wdata (ver_reg),
        .re    (re),
        .raddr (sidx_reg[AW-1:0]),
        .rdata (ver_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            key_reg <= in_data[KEY_BITS-1:0];
            ver_reg <= in_data[VER_LSB +: VER_W];
        end
        if (cmd.step)
        begin
            cidx_reg <= sidx_reg[AW-1:0];
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            count_reg  <= COUNT_W'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sidx_reg      <= '0;
            cvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                sidx_reg <= '0;
                cvld_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                cvld_reg <= issue_ok;
                if (issue_ok)
                begin
                    sidx_reg <= sidx_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_TDATA_W - STATUS_W - COUNT_W){1'b0}}, count_reg, status_reg};

endmodule

[rtl/versioned_key_table.sv]
// Versioned key table: add and update items against a table filled in order.
// An accepted item is searched for by reading one stored key and version per cycle from the RAMs.
// A new item is accepted only in the idle state, once the result of the last one is registered,
// so the linear search over the single read port of the key and version RAMs and a stalled
// output both hold off the next item.
// Reset clears the entry count and the control state; RAM contents are never read unwritten.
module versioned_key_table import vkt_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key[63:0], version[94:64], zero pad.
    input  logic [0:0]             s_axis_tuser,   // op.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status[2:0], count[8:3], zero pad.
);

    vkt_cmd_t cmd;
    vkt_sts_t sts;

    vkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vkt_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser[0]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
